[src/hftm_pkg.sv]
// Shared constants and types for the filmic tonemap pixel pipeline.
package hftm_pkg;

  // Q16 unity and curve constants (truncated to Q16)
  localparam logic [16:0] Q_ONE       = 17'd65536;
  localparam logic [17:0] K_251       = 18'd164495;
  localparam logic [17:0] K_243       = 18'd159252;
  localparam logic [21:0] K_003       = 22'd1966;
  localparam logic [21:0] K_059       = 22'd38666;
  localparam logic [13:0] K_014       = 14'd9175;

  // Rec.709 luminance weights in Q16
  localparam logic [12:0] W_B         = 13'd4732;
  localparam logic [15:0] W_G         = 16'd46871;
  localparam logic [13:0] W_R         = 14'd13933;

  localparam logic [15:0] EXP_RESET   = 16'd256;
  localparam logic [15:0] SAT_NEUTRAL = 16'd4096;
  localparam logic [7:0]  ALPHA_BYTE  = 8'hFF;

  // divide by 255: floor(w * RECIP_255 / 2^36) is exact for w < 2^28
  localparam logic [28:0] RECIP_255   = 29'd269488145;
  // exposed value saturates to 16.0 once radiance*exposure + 127 reaches this
  localparam logic [40:0] X_SAT_LIMIT = 41'd267387135;
  localparam logic [20:0] X_MAX       = 21'd1048576;

  // pipeline depths
  localparam int CURVE_LAT = 23;
  localparam int CHROMA_LAT = 5;
  localparam int SQRT_LAT  = 19;
  localparam int PIPE_LAT  = CURVE_LAT + CHROMA_LAT + SQRT_LAT + 1;

  typedef enum logic [1:0] {
    REG_EXPOSURE   = 2'd0,
    REG_SATURATION = 2'd1,
    REG_LINEAR     = 2'd2
  } cfg_reg_e;

endpackage

[src/hftm_curve.sv]
// Exposure scale and pipelined rational filmic curve for one channel.
module hftm_curve (
  input  logic        clk_i,
  input  logic [23:0] rad_i,
  input  logic [15:0] exposure_i,
  output logic [16:0] y_o
);
  import hftm_pkg::*;

  logic [39:0] prod_q;
  logic [40:0] bias;
  logic        sat_q;
  logic [56:0] recip_q;
  logic [20:0] x;
  logic [38:0] ka, kb;
  logic [20:0] x_q;
  logic [21:0] a_q, b_q;
  logic [42:0] num_q, den_q;

  // long division: one quotient bit per stage
  logic [59:0] rem_q [19];
  logic [42:0] dv_q  [19];
  logic [17:0] quo_q [19];

  assign bias = {1'b0, prod_q} + 41'd127;
  assign x    = sat_q ? X_MAX : recip_q[56:36];
  assign ka   = x * K_251;
  assign kb   = x * K_243;

  always_ff @(posedge clk_i) begin
    prod_q  <= rad_i * exposure_i;
    sat_q   <= (bias >= X_SAT_LIMIT);
    recip_q <= bias[27:0] * RECIP_255;
    x_q     <= x;
    a_q     <= ka[37:16] + K_003;
    b_q     <= kb[37:16] + K_059;
    num_q   <= x_q * a_q;
    den_q   <= x_q * b_q + 43'({K_014, 16'b0});
    rem_q[0] <= {1'b0, num_q, 16'b0} + {18'b0, den_q[42:1]};
    dv_q[0]  <= den_q;
    quo_q[0] <= '0;
  end

  for (genvar k = 0; k < 18; k++) begin : g_div
    localparam int SH = 17 - k;
    logic [59:0] trial;
    logic        ge;
    assign trial = 60'(dv_q[k]) << SH;
    assign ge    = (rem_q[k] >= trial);
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? (rem_q[k] - trial) : rem_q[k];
      quo_q[k+1] <= quo_q[k] | (ge ? (18'd1 << SH) : 18'd0);
      dv_q[k+1]  <= dv_q[k];
    end
  end

  // quotients above one clamp to one
  assign y_o = (quo_q[18] > 18'(Q_ONE)) ? Q_ONE : quo_q[18][16:0];

endmodule

[src/hftm_sqrt.sv]
// Pipelined rounded square root encode in Q16, bypassed when linear mode is off.
module hftm_sqrt (
  input  logic        clk_i,
  input  logic [16:0] c_i,
  input  logic        linear_i,
  output logic [16:0] u_o
);
  import hftm_pkg::*;

  logic [32:0] rem_q  [18];
  logic [16:0] root_q [18];
  logic [16:0] c_q    [18];
  logic [16:0] u_q;

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= {c_i, 16'b0};
    root_q[0] <= '0;
    c_q[0]    <= c_i;
  end

  for (genvar k = 0; k < 17; k++) begin : g_bit
    localparam int BI = 16 - k;
    logic [34:0] trial;
    logic        ge;
    assign trial = (35'(root_q[k]) << (BI + 1)) + (35'd1 << (2 * BI));
    assign ge    = ({2'b0, rem_q[k]} >= trial);
    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= ge ? 33'({2'b0, rem_q[k]} - trial) : rem_q[k];
      root_q[k+1] <= root_q[k] | (ge ? (17'd1 << BI) : 17'd0);
      c_q[k+1]    <= c_q[k];
    end
  end

  // round to nearest: remainder above root means the next integer is closer
  always_ff @(posedge clk_i) begin
    if (linear_i) begin
      u_q <= (rem_q[17] > 33'(root_q[17])) ? (root_q[17] + 17'd1) : root_q[17];
    end else begin
      u_q <= c_q[17];
    end
  end

  assign u_o = u_q;

endmodule

[src/hdr_filmic_tonemap_pixel.sv]
// Top level: filmic tonemap of one HDR pixel to a packed BGRA word.
//
//  channel | signals                                   | direction | handshake
//  --------+-------------------------------------------+-----------+-------------------------
//  item in | start_i, busy_o, {blue,green,red}_radiance_i | in        | start_i && !busy_o
//  result  | result_valid_o, pixel_word_o              | out       | strobe, one cycle
//  config  | cfg_valid_i, cfg_ready_o, cfg_index_i/data | in        | cfg_valid_i && cfg_ready_o
//
// One item per clock; each accepted item passes, in order, through exposure and the
// curve (a bit-per-stage quotient), luminance and saturation, the bit-per-stage square
// root and the pack register, and leaves with a result_valid_o strobe.
// busy_o is always low; there is no backpressure and the receiver cannot stall.
// Reset clears the valid line and loads register defaults; data stages are not reset.
module hdr_filmic_tonemap_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [23:0] blue_radiance_i,
  input  logic [23:0] green_radiance_i,
  input  logic [23:0] red_radiance_i,
  output logic        result_valid_o,
  output logic [31:0] pixel_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import hftm_pkg::*;

  // configuration registers
  logic [15:0] exposure_q, saturation_q;
  logic        linear_q;

  logic [PIPE_LAT-1:0] valid_q;
  logic                accept;

  // per channel: 0 blue, 1 green, 2 red
  logic [23:0] rad   [3];
  logic [16:0] y_c   [3];
  logic [16:0] y1_q  [3];
  logic [16:0] y2_q  [3];
  logic [16:0] y3_q  [3];
  logic [16:0] y4_q  [3];
  logic [16:0] mag3_q[3];
  logic        neg3_q[3];
  logic        neg4_q[3];
  logic [32:0] sp4_q [3];
  logic [16:0] c5_q  [3];
  logic [16:0] u_c   [3];
  logic [7:0]  byte_c[3];

  logic [29:0] wb1_q;
  logic [32:0] wg1_q;
  logic [30:0] wr1_q;
  logic [33:0] lsum;
  logic [16:0] lum2_q, lum3_q, lum4_q;

  logic [31:0] pixel_q;

  assign accept      = start_i && !busy_o;
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  assign rad[0] = blue_radiance_i;
  assign rad[1] = green_radiance_i;
  assign rad[2] = red_radiance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exposure_q   <= EXP_RESET;
      saturation_q <= SAT_NEUTRAL;
      linear_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_EXPOSURE:   exposure_q   <= cfg_data_i;
        REG_SATURATION: saturation_q <= cfg_data_i;
        REG_LINEAR:     linear_q     <= cfg_data_i[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // valid bits ride alongside the data stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[PIPE_LAT-2:0], accept};
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_curve
    hftm_curve u_curve (
      .clk_i      (clk_i),
      .rad_i      (rad[c]),
      .exposure_i (exposure_q),
      .y_o        (y_c[c])
    );
  end

  // stage 1: weighted channels
  always_ff @(posedge clk_i) begin
    wb1_q <= y_c[0] * W_B;
    wg1_q <= y_c[1] * W_G;
    wr1_q <= y_c[2] * W_R;
    y1_q  <= y_c;
  end

  // stage 2: luminance, rounded half up
  assign lsum = 34'(wb1_q) + 34'(wg1_q) + 34'(wr1_q) + 34'd32768;

  always_ff @(posedge clk_i) begin
    lum2_q <= lsum[32:16];
    y2_q   <= y1_q;
  end

  // stage 3: distance from luminance as sign and magnitude
  for (genvar c = 0; c < 3; c++) begin : g_diff
    always_ff @(posedge clk_i) begin
      neg3_q[c] <= (y2_q[c] < lum2_q);
      mag3_q[c] <= (y2_q[c] < lum2_q) ? (lum2_q - y2_q[c]) : (y2_q[c] - lum2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    lum3_q <= lum2_q;
    y3_q   <= y2_q;
  end

  // stage 4: scale the chroma distance
  for (genvar c = 0; c < 3; c++) begin : g_scale
    always_ff @(posedge clk_i) begin
      sp4_q[c]  <= mag3_q[c] * saturation_q;
      neg4_q[c] <= neg3_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    lum4_q <= lum3_q;
    y4_q   <= y3_q;
  end

  // stage 5: round magnitude, reapply sign, clamp to 0..1; neutral saturation passes the curve value through
  for (genvar c = 0; c < 3; c++) begin : g_sat
    logic [32:0]        qround;
    logic [20:0]        qmag;
    logic signed [22:0] cs;
    logic [16:0]        cclamp;
    always_comb begin
      qround = sp4_q[c] + 33'd2048;
      qmag   = qround[32:12];
      cs     = neg4_q[c] ? ($signed({6'b0, lum4_q}) - $signed({2'b0, qmag}))
                         : ($signed({6'b0, lum4_q}) + $signed({2'b0, qmag}));
      if (cs < 0) begin
        cclamp = '0;
      end else if (cs > $signed({6'b0, Q_ONE})) begin
        cclamp = Q_ONE;
      end else begin
        cclamp = cs[16:0];
      end
    end
    always_ff @(posedge clk_i) begin
      c5_q[c] <= (saturation_q == SAT_NEUTRAL) ? y4_q[c] : cclamp;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_enc
    logic [24:0] scaled;
    hftm_sqrt u_sqrt (
      .clk_i    (clk_i),
      .c_i      (c5_q[c]),
      .linear_i (linear_q),
      .u_o      (u_c[c])
    );
    // byte = (u * 255 + 32768) >> 16
    assign scaled    = 25'({u_c[c], 8'b0}) - 25'(u_c[c]) + 25'd32768;
    assign byte_c[c] = scaled[23:16];
  end

  always_ff @(posedge clk_i) begin
    pixel_q <= {ALPHA_BYTE, byte_c[2], byte_c[1], byte_c[0]};
  end

  assign result_valid_o = valid_q[PIPE_LAT-1];
  assign pixel_word_o   = pixel_q;

  // a strobe only ever follows an accepted item by the fixed latency
  a_strobe_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, PIPE_LAT))
    else $error("result strobe without an item accepted PIPE_LAT cycles earlier");

  a_alpha_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (pixel_word_o[31:24] == ALPHA_BYTE))
    else $error("alpha byte not opaque on a result");

  a_curve_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[CURVE_LAT-1] |-> (y_c[0] <= Q_ONE && y_c[1] <= Q_ONE && y_c[2] <= Q_ONE))
    else $error("curve output above one");

endmodule
